@@ rtl/core/mmgrt_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the monitor mixer.
// Depends on nothing; imported by every module under rtl/core.
package mmgrt_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = 8;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [31:0] UNITY_Q31 = 32'h8000_0000;
    localparam logic [15:0] GAIN_MAX = 16'd32768;
    localparam logic signed [27:0] MIX_CEIL = 28'sd8220836;
    localparam logic [31:0] TONE_INC = 32'd39370534;

    localparam logic [2:0] REG_BUFFER_FRAMES = 3'd0;
    localparam logic [2:0] REG_INSTRUMENT_GAIN = 3'd1;
    localparam logic [2:0] REG_VOICE_GAIN = 3'd2;
    localparam logic [2:0] REG_INSTRUMENT_ON = 3'd3;
    localparam logic [2:0] REG_VOICE_ON = 3'd4;

    typedef struct packed {
        logic signed [23:0] instrument_sample;
        logic signed [23:0] voice_sample;
        logic signed [23:0] remote_sample;
        logic               tone_request;
    } mmgrt_in_t;

    typedef struct packed {
        logic signed [23:0] mixed_sample;
        logic               buffer_end;
        logic [22:0]        output_peak;
        logic [23:0]        instrument_peak;
        logic [23:0]        voice_peak;
    } mmgrt_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_I_INIT,
        ST_DIV_I_RUN,
        ST_DIV_V_INIT,
        ST_DIV_V_RUN,
        ST_DIV_V_STORE,
        ST_RAMP,
        ST_MUL_I,
        ST_MUL_V,
        ST_MIX,
        ST_OUT
    } mmgrt_state_t;

    typedef struct packed {
        logic load;
        logic div_init_i;
        logic div_init_v;
        logic div_step;
        logic store_i;
        logic store_v;
        logic ramp;
        logic mul_i;
        logic mul_v;
        logic mix;
        logic emit;
    } mmgrt_cmd_t;

    typedef struct packed {
        logic first_frame;
        logic div_last;
        logic out_free;
    } mmgrt_stat_t;

    typedef logic [20:0] sine_word_t;
    typedef sine_word_t sine_rom_t [0:SINE_DEPTH];

    // Taylor series through x^13 in Q30, one entry per quarter-wave step.
    function automatic sine_rom_t build_sine();
        sine_rom_t         rom;
        logic [63:0]       x;
        logic [63:0]       term;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_DEPTH; i++)
        begin
            x = HALF_PI_Q30 * 64'(i) / 64'(SINE_DEPTH);
            term = x;
            sum = $signed(x);
            for (int k = 1; k <= 6; k++)
            begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > 64'sd1073741824)
                sum = 64'sd1073741824;
            rom[i] = 21'((64'(sum) + 64'd512) >> 10);
        end
        return rom;
    endfunction

endpackage

@@ rtl/core/mmgrt_ctrl.sv @@
// Mixer sequencer: one word at a time through divide (first frame), ramp, mix, emit.
// Depends on mmgrt_pkg.
module mmgrt_ctrl
    import mmgrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mmgrt_stat_t stat,
    output mmgrt_cmd_t  cmd
);

    mmgrt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = stat.first_frame ? ST_DIV_I_INIT : ST_RAMP;
                end
            end
            ST_DIV_I_INIT:
            begin
                cmd.div_init_i = 1'b1;
                state_next = ST_DIV_I_RUN;
            end
            ST_DIV_I_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_DIV_V_INIT;
            end
            ST_DIV_V_INIT:
            begin
                cmd.store_i = 1'b1;
                cmd.div_init_v = 1'b1;
                state_next = ST_DIV_V_RUN;
            end
            ST_DIV_V_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_DIV_V_STORE;
            end
            ST_DIV_V_STORE:
            begin
                cmd.store_v = 1'b1;
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                cmd.ramp = 1'b1;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_i = 1'b1;
                state_next = ST_MUL_V;
            end
            ST_MUL_V:
            begin
                cmd.mul_v = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/mmgrt_dp.sv @@
// Datapath of the monitor mixer: ramp divider, shared multiplier, tone NCO, limiter, peaks.
// Depends on mmgrt_pkg; driven by mmgrt_ctrl commands.
module mmgrt_dp
    import mmgrt_pkg::*;
#(
    parameter int MAX_BUFFER_FRAMES = 16384,
    parameter int TONE_FRAMES = 48000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mmgrt_cmd_t  cmd,
    output mmgrt_stat_t stat,
    input  mmgrt_in_t   in_data,
    input  logic [14:0] buffer_frames,
    input  logic [15:0] instrument_gain,
    input  logic [15:0] voice_gain,
    input  logic        instrument_on,
    input  logic        voice_on,
    output logic        out_valid,
    input  logic        out_ready,
    output mmgrt_out_t  out_data
);

    localparam int FW = $clog2(MAX_BUFFER_FRAMES + 1);
    localparam int PW = $clog2(MAX_BUFFER_FRAMES);
    localparam int TW = $clog2(TONE_FRAMES + 1);
    localparam sine_rom_t SINE_ROM = build_sine();

    mmgrt_in_t          in_reg;
    logic [PW-1:0]      pos_reg;
    logic [31:0]        gi_reg, gv_reg;
    logic signed [33:0] si_reg, sv_reg;
    logic               pend_reg;
    logic [TW-1:0]      left_reg;
    logic [31:0]        phase_reg;
    logic [23:0]        mpk_reg, ipk_reg, vpk_reg;
    logic [FW-1:0]      rem_reg;
    logic [31:0]        quo_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    logic signed [56:0] prod_reg;
    logic signed [26:0] termi_reg;
    logic signed [21:0] tone_reg;
    logic               tone_on_reg;
    logic signed [23:0] mix_reg;
    logic               out_valid_reg;
    mmgrt_out_t         out_reg;

    logic [FW-1:0]      frames;
    logic [31:0]        ti, tv;
    logic signed [32:0] diff;
    logic [FW:0]        r2;
    logic signed [33:0] step_q;
    logic signed [34:0] ri, rv;
    logic [31:0]        gi_new, gv_new;
    logic signed [23:0] mul_a;
    logic [31:0]        mul_b;
    logic signed [56:0] prod_new;
    logic signed [57:0] rnd;
    logic [SINE_IDX_W-1:0] idx;
    logic [SINE_IDX_W:0]   ridx;
    logic signed [27:0] sum;
    logic signed [23:0] mix_c;
    logic [23:0]        amix, ainst, avoice;
    logic [23:0]        mpk_n, ipk_n, vpk_n;
    logic               last;
    logic               pend_n;

    // clamp buffer length to 1..MAX
    always_comb
    begin
        if (buffer_frames == 15'd0)
            frames = FW'(1);
        else if (17'(buffer_frames) > 17'(MAX_BUFFER_FRAMES))
            frames = FW'(MAX_BUFFER_FRAMES);
        else
            frames = FW'(buffer_frames);
    end

    assign ti = !instrument_on ? 32'd0
              : {(instrument_gain > GAIN_MAX ? GAIN_MAX : instrument_gain), 16'd0};
    assign tv = !voice_on ? 32'd0
              : {(voice_gain > GAIN_MAX ? GAIN_MAX : voice_gain), 16'd0};

    assign diff = cmd.div_init_v ? ($signed({1'b0, tv}) - $signed({1'b0, gv_reg}))
                                 : ($signed({1'b0, ti}) - $signed({1'b0, gi_reg}));
    assign r2 = {rem_reg[FW-1:0], quo_reg[31]};
    assign step_q = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});

    assign ri = $signed({3'b000, gi_reg}) + 35'(si_reg);
    assign rv = $signed({3'b000, gv_reg}) + 35'(sv_reg);
    assign gi_new = ri < 0 ? 32'd0 : (ri > $signed({3'b000, UNITY_Q31}) ? UNITY_Q31 : ri[31:0]);
    assign gv_new = rv < 0 ? 32'd0 : (rv > $signed({3'b000, UNITY_Q31}) ? UNITY_Q31 : rv[31:0]);

    assign mul_a = cmd.mul_v ? in_reg.voice_sample : in_reg.instrument_sample;
    assign mul_b = cmd.mul_v ? gv_reg : gi_reg;
    assign prod_new = mul_a * $signed({1'b0, mul_b});
    assign rnd = 58'(prod_reg) + 58'sd1073741824;

    assign idx = phase_reg[29 -: SINE_IDX_W];
    assign ridx = phase_reg[30] ? (SINE_IDX_W + 1)'(SINE_DEPTH) - {1'b0, idx} : {1'b0, idx};

    assign sum = 28'(termi_reg) + 28'($signed(rnd[57:31])) + 28'(in_reg.remote_sample)
               + (tone_on_reg ? 28'(tone_reg) : 28'sd0);
    assign mix_c = sum > MIX_CEIL ? 24'(MIX_CEIL) : (sum < -MIX_CEIL ? 24'(-MIX_CEIL) : sum[23:0]);

    assign amix = mix_reg[23] ? 24'(-mix_reg) : 24'(mix_reg);
    assign ainst = in_reg.instrument_sample[23] ? 24'(-25'(in_reg.instrument_sample))
                                                : 24'(in_reg.instrument_sample);
    assign avoice = in_reg.voice_sample[23] ? 24'(-25'(in_reg.voice_sample))
                                            : 24'(in_reg.voice_sample);
    assign mpk_n = amix > mpk_reg ? amix : mpk_reg;
    assign ipk_n = ainst > ipk_reg ? ainst : ipk_reg;
    assign vpk_n = avoice > vpk_reg ? avoice : vpk_reg;
    assign last = (FW'(pos_reg) + FW'(1)) >= frames;
    assign pend_n = pend_reg | in_data.tone_request;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            gi_reg <= UNITY_Q31;
            gv_reg <= UNITY_Q31;
            si_reg <= '0;
            sv_reg <= '0;
            pend_reg <= 1'b0;
            left_reg <= '0;
            phase_reg <= '0;
            mpk_reg <= '0;
            ipk_reg <= '0;
            vpk_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (pos_reg == '0 && pend_n)
                begin
                    pend_reg <= 1'b0;
                    left_reg <= TW'(TONE_FRAMES);
                    phase_reg <= '0;
                end
                else
                    pend_reg <= pend_n;
            end
            if (cmd.div_init_i || cmd.div_init_v)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 5'd1;
            if (cmd.store_i)
                si_reg <= step_q;
            if (cmd.store_v)
                sv_reg <= step_q;
            if (cmd.ramp)
            begin
                gi_reg <= gi_new;
                gv_reg <= gv_new;
            end
            if (cmd.mix && tone_on_reg)
            begin
                phase_reg <= phase_reg + TONE_INC;
                left_reg <= left_reg - TW'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.emit)
            begin
                if (last)
                begin
                    pos_reg <= '0;
                    mpk_reg <= '0;
                    ipk_reg <= '0;
                    vpk_reg <= '0;
                    gi_reg <= ti;
                    gv_reg <= tv;
                end
                else
                begin
                    pos_reg <= pos_reg + PW'(1);
                    mpk_reg <= mpk_n;
                    ipk_reg <= ipk_n;
                    vpk_reg <= vpk_n;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_data;
        if (cmd.div_init_i || cmd.div_init_v)
        begin
            rem_reg <= '0;
            quo_reg <= diff[32] ? 32'(-diff) : diff[31:0];
            neg_reg <= diff[32];
        end
        else if (cmd.div_step)
        begin
            if (r2 >= {1'b0, frames})
            begin
                rem_reg <= FW'(r2 - {1'b0, frames});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= r2[FW-1:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.ramp)
        begin
            tone_reg <= phase_reg[31] ? -$signed({1'b0, SINE_ROM[ridx]})
                                      : $signed({1'b0, SINE_ROM[ridx]});
            tone_on_reg <= left_reg != '0;
        end
        if (cmd.mul_i || cmd.mul_v)
            prod_reg <= prod_new;
        if (cmd.mul_v)
            termi_reg <= rnd[57:31];
        if (cmd.mix)
            mix_reg <= mix_c;
        if (cmd.emit)
        begin
            out_reg.mixed_sample <= mix_reg;
            out_reg.buffer_end <= last;
            out_reg.output_peak <= last ? mpk_n[22:0] : 23'd0;
            out_reg.instrument_peak <= last ? ipk_n : 24'd0;
            out_reg.voice_peak <= last ? vpk_n : 24'd0;
        end
    end

    assign stat.first_frame = pos_reg == '0;
    assign stat.div_last = cnt_reg == 5'd31;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
        gi_reg <= UNITY_Q31 && gv_reg <= UNITY_Q31)
        else $error("ramped gain above unity");
    a_peaks_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.buffer_end |-> out_data.output_peak == 23'd0
        && out_data.instrument_peak == 24'd0 && out_data.voice_peak == 24'd0)
        else $error("peaks reported off buffer end");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || out_ready)
        else $error("output word overwritten");
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 28'(out_data.mixed_sample) <= MIX_CEIL
        && 28'(out_data.mixed_sample) >= -MIX_CEIL)
        else $error("mix outside limiter range");

endmodule

@@ rtl/core/monitor_mixer_gain_ramp_tone_core.sv @@
// Top level of the monitor mixer with gain ramps, test tone and limiter.
// Depends on mmgrt_pkg, mmgrt_ctrl and mmgrt_dp.
//
// Usage:
//   in_valid/in_ready carry one input word per audio frame: instrument, voice
//   and summed remote samples (signed Q1.23) plus a tone request bit.
//   out_valid/out_ready carry one mixed word per input word, with the buffer
//   peaks attached on the last frame of each buffer (zero otherwise).
//   The APB port holds buffer_frames, the two target gains and the two source
//   enables at byte addresses 0, 4, 8, 12, 16; write them only while idle.
// Timing:
//   A frame inside a buffer goes from accept through ramp, the two multiplies,
//   mix and emit. The first frame of a buffer first runs two 32-step restoring
//   divisions of the gain change by the buffer length, on one shared divider.
//   One word is worked on at a time; the next is taken once the current one
//   sits in the output register.
// Reset:
//   Gains return to unity, ramps, tone and peaks clear, registers take their
//   defaults. No clearing pass; the sine table is constant logic.
// Stall:
//   While out_ready is low the finished word holds in the output register;
//   one more frame is computed and then waits, and in_ready drops.
module monitor_mixer_gain_ramp_tone_core
    import mmgrt_pkg::*;
#(
    parameter int MAX_BUFFER_FRAMES = 16384,
    parameter int TONE_FRAMES = 48000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mmgrt_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mmgrt_out_t  out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [14:0] frames_reg;
    logic [15:0] igain_reg, vgain_reg;
    logic        ion_reg, von_reg;
    logic        wr;
    mmgrt_cmd_t  cmd;
    mmgrt_stat_t stat;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // register file; decode by word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= 15'd256;
            igain_reg <= GAIN_MAX;
            vgain_reg <= GAIN_MAX;
            ion_reg <= 1'b1;
            von_reg <= 1'b1;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_BUFFER_FRAMES:   frames_reg <= pwdata[14:0];
                REG_INSTRUMENT_GAIN: igain_reg <= pwdata[15:0];
                REG_VOICE_GAIN:      vgain_reg <= pwdata[15:0];
                REG_INSTRUMENT_ON:   ion_reg <= pwdata[0];
                REG_VOICE_ON:        von_reg <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BUFFER_FRAMES:   prdata = {17'd0, frames_reg};
            REG_INSTRUMENT_GAIN: prdata = {16'd0, igain_reg};
            REG_VOICE_GAIN:      prdata = {16'd0, vgain_reg};
            REG_INSTRUMENT_ON:   prdata = {31'd0, ion_reg};
            REG_VOICE_ON:        prdata = {31'd0, von_reg};
            default:             prdata = 32'd0;
        endcase
    end

    mmgrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmgrt_dp #(
        .MAX_BUFFER_FRAMES (MAX_BUFFER_FRAMES),
        .TONE_FRAMES       (TONE_FRAMES)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_data         (in_data),
        .buffer_frames   (frames_reg),
        .instrument_gain (igain_reg),
        .voice_gain      (vgain_reg),
        .instrument_on   (ion_reg),
        .voice_on        (von_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data)
    );

endmodule
